[hw/rtl/urc_pkg.sv]
// Shared types, constants and register codes for the ultrasonic range controller.
package urc_pkg;

    // Defaults for top-level parameters
    localparam int CLOCKS_PER_US_DEF = 16;
    localparam int COUNT_BITS_DEF    = 24;

    // Number of sensors that accept a start request
    localparam int SENSORS    = 4;
    localparam int SENSOR_W   = 2;
    localparam int LINE_W     = 4;

    // Distance arithmetic: distance = MM_PER_STEP * two_us_steps / STEP_DIV
    localparam int            DIST_W      = 18;
    localparam logic [17:0]   DIST_MAX    = 18'h3FFFF;
    localparam int            MM_PER_STEP = 343;
    localparam int            STEP_DIV    = 1000;
    localparam int            REM_W       = 10;

    // Configuration registers
    localparam int          CFG_ADDR_W        = 1;
    localparam int          CFG_DATA_W        = 18;
    localparam logic [0:0]  REG_TRIGGER_TICKS = 1'b0;
    localparam logic [0:0]  REG_THRESHOLD_MM  = 1'b1;
    localparam logic [15:0] TRIG_TICKS_RST    = 16'd160;
    localparam logic [17:0] THRESHOLD_RST     = 18'd0;

    // Request kinds on s_tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Measurement phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_COUNT
    } phase_t;

    // Control from the sequencer to the distance accumulator
    typedef struct packed {
        logic load;   // echo seen high: first tick of the pulse
        logic step;   // one more tick of echo high
    } acc_ctrl_t;

    // One result item
    typedef struct packed {
        logic [3:0]  red_marks;
        logic [3:0]  green_marks;
        logic        beyond_threshold;
        logic [17:0] distance_mm;
        logic        done_res;
        logic        busy_res;
        logic [3:0]  trigger_lines;
    } result_t;

endpackage

[hw/rtl/ultrasonic_range_controller.sv]
// Top level of the four-sensor ultrasonic range controller.
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  ---------+-----------+--------------------------------------------+---------
//  s_       | in        | sensor[1:0], echo_levels[5:2]              | req_type
//  m_       | out       | trigger_lines, busy, done, distance_mm,    | -
//           |           | beyond_threshold, green_marks, red_marks   |
//  cfg_     | in        | index 0 trigger_ticks, index 1 threshold_mm|
//
// Each transaction passes one input register, then one result register.
// One transaction per cycle is sustained while m_tready stays high; the
// sequencer updates its state once per transaction.
// Reset (aresetn low, synchronous) returns to idle with all marks off.
// A stalled m_ side holds the result and the input register fills; s_tready
// drops only when both are full.
module ultrasonic_range_controller #(
    parameter int CLOCKS_PER_US = urc_pkg::CLOCKS_PER_US_DEF,
    parameter int COUNT_BITS    = urc_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [urc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [urc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // sensor[1:0], echo_levels[5:2]
    input  logic                               s_tuser,   // req_type
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata    // trigger_lines[3:0], busy[4],
                                                          // done[5], distance_mm[23:6],
                                                          // beyond[24], green[28:25],
                                                          // red[32:29]
);
    import urc_pkg::*;

    logic [15:0]        trig_ticks_reg;
    logic [17:0]        threshold_reg;
    logic               in_valid_reg;
    logic               in_type_reg;
    logic [1:0]         in_sensor_reg;
    logic [3:0]         in_echo_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            result;
    acc_ctrl_t          acc_ctrl;
    logic [17:0]        distance_mm;
    logic               advance;

    // An item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg <= TRIG_TICKS_RST;
            threshold_reg  <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TRIGGER_TICKS: trig_ticks_reg <= cfg_wdata[15:0];
                REG_THRESHOLD_MM:  threshold_reg  <= cfg_wdata[17:0];
                default:           trig_ticks_reg <= trig_ticks_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg   <= s_tuser;
            in_sensor_reg <= s_tdata[1:0];
            in_echo_reg   <= s_tdata[5:2];
        end
    end

    urc_dist_acc #(
        .CLOCKS_PER_US (CLOCKS_PER_US)
    ) u_dist_acc (
        .aclk        (aclk),
        .ctrl        (acc_ctrl),
        .distance_mm (distance_mm)
    );

    urc_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .req_type      (in_type_reg),
        .sensor        (in_sensor_reg),
        .echo_levels   (in_echo_reg),
        .trigger_ticks (trig_ticks_reg),
        .threshold_mm  (threshold_reg),
        .distance_mm   (distance_mm),
        .acc_ctrl      (acc_ctrl),
        .result        (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

endmodule

[hw/rtl/urc_dist_acc.sv]
// Running distance accumulator: tracks millimetres while the echo pulse is counted.
module urc_dist_acc #(
    parameter int CLOCKS_PER_US = urc_pkg::CLOCKS_PER_US_DEF
) (
    input  logic                aclk,
    input  urc_pkg::acc_ctrl_t  ctrl,
    output logic [17:0]         distance_mm
);
    import urc_pkg::*;

    // Prescaler modulus that spans two microseconds
    localparam int PRE_MOD = 2 * CLOCKS_PER_US;
    localparam int PRE_W   = $clog2(PRE_MOD);

    logic [PRE_W-1:0]  pre_reg,  pre_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [DIST_W-1:0] mm_reg,   mm_next;
    logic [REM_W:0]    rem_sum;

    assign rem_sum = {1'b0, rem_reg} + (REM_W+1)'(MM_PER_STEP);

    // Each completed two microseconds adds 343/1000 mm, kept as quotient and remainder
    always_comb begin
        pre_next = pre_reg;
        rem_next = rem_reg;
        mm_next  = mm_reg;
        if (ctrl.load) begin
            pre_next = PRE_W'(1);
            rem_next = '0;
            mm_next  = '0;
        end else if (ctrl.step) begin
            if (pre_reg == PRE_W'(PRE_MOD - 1)) begin
                pre_next = '0;
                if (rem_sum >= (REM_W+1)'(STEP_DIV)) begin
                    rem_next = REM_W'(rem_sum - (REM_W+1)'(STEP_DIV));
                    if (mm_reg != DIST_MAX) begin
                        mm_next = mm_reg + DIST_W'(1);
                    end
                end else begin
                    rem_next = rem_sum[REM_W-1:0];
                end
            end else begin
                pre_next = pre_reg + PRE_W'(1);
            end
        end
    end

    // Payload registers, loaded before use
    always_ff @(posedge aclk) begin
        pre_reg <= pre_next;
        rem_reg <= rem_next;
        mm_reg  <= mm_next;
    end

    assign distance_mm = mm_reg;

endmodule

[hw/rtl/urc_seq.sv]
// Measurement sequencer: phase, trigger timing, echo count and sensor marks.
module urc_seq #(
    parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                req_type,
    input  logic [1:0]          sensor,
    input  logic [3:0]          echo_levels,
    input  logic [15:0]         trigger_ticks,
    input  logic [17:0]         threshold_mm,
    input  logic [17:0]         distance_mm,
    output urc_pkg::acc_ctrl_t  acc_ctrl,
    output urc_pkg::result_t    result
);
    import urc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    phase_t                  phase_reg,  phase_next;
    logic [SENSOR_W-1:0]     sensor_reg, sensor_next;
    logic [COUNT_BITS-1:0]   count_reg,  count_next;
    logic [LINE_W-1:0]       green_reg,  green_next;
    logic [LINE_W-1:0]       red_reg,    red_next;
    logic [COUNT_BITS-1:0]   count_inc;
    logic                    echo;
    logic                    near;
    logic                    done_flag;
    logic                    sensor_ok;

    assign count_inc = count_reg + COUNT_BITS'(1);
    assign echo      = echo_levels[sensor_reg];
    assign near      = (distance_mm <= threshold_mm);
    assign sensor_ok = ({1'b0, sensor} < (SENSOR_W+1)'(SENSORS));

    // Next state
    always_comb begin
        phase_next    = phase_reg;
        sensor_next   = sensor_reg;
        count_next    = count_reg;
        green_next    = green_reg;
        red_next      = red_reg;
        done_flag     = 1'b0;
        acc_ctrl.load = 1'b0;
        acc_ctrl.step = 1'b0;
        if (advance) begin
            if (req_type == REQ_START) begin
                if (phase_reg == PH_IDLE && sensor_ok) begin
                    sensor_next = sensor;
                    count_next  = '0;
                    phase_next  = PH_TRIG;
                end
            end else begin
                case (phase_reg)
                    PH_TRIG: begin
                        // zero trigger_ticks ends the pulse after one tick, like one
                        if (count_inc >= COUNT_BITS'(trigger_ticks)) begin
                            count_next = '0;
                            phase_next = PH_WAIT;
                        end else begin
                            count_next = count_inc;
                        end
                    end
                    PH_WAIT: begin
                        if (echo) begin
                            count_next    = COUNT_BITS'(1);
                            acc_ctrl.load = 1'b1;
                            phase_next    = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        if (echo) begin
                            if (count_reg != COUNT_MAX) begin
                                count_next    = count_inc;
                                acc_ctrl.step = 1'b1;
                            end
                        end else begin
                            done_flag              = 1'b1;
                            green_next[sensor_reg] = 1'b1;
                            red_next[sensor_reg]   = near;
                            count_next             = '0;
                            phase_next             = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result item, showing state after this transaction
    always_comb begin
        result.trigger_lines    = (phase_next == PH_TRIG) ?
                                  ~(LINE_W'(1) << sensor_next) : '1;
        result.busy_res         = (phase_next != PH_IDLE);
        result.done_res         = done_flag;
        result.distance_mm      = done_flag ? distance_mm : '0;
        result.beyond_threshold = done_flag && !near;
        result.green_marks      = green_next;
        result.red_marks        = red_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            sensor_reg <= '0;
            count_reg  <= '0;
            green_reg  <= '0;
            red_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            sensor_reg <= sensor_next;
            count_reg  <= count_next;
            green_reg  <= green_next;
            red_reg    <= red_next;
        end
    end

endmodule

[hw/rtl/urc_checker.sv]
// Port-level checker for the ultrasonic range controller, bound to the top level.
module urc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A completed measurement leaves the block idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5]) |-> !m_tdata[4])
        else $error("done result still shows busy");

    // No trigger pulse while idle, and never more than one line low
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[4] || m_tdata[3:0] == 4'hF) &&
                      $countones(~m_tdata[3:0]) <= 1))
        else $error("bad trigger line pattern");

    // Distance and beyond flag only carry data on a done result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[5]) |-> (m_tdata[24:6] == 19'd0))
        else $error("distance shown without done");

    // A done result always has at least one green mark set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5]) |-> (m_tdata[28:25] != 4'd0))
        else $error("done without green mark");

    // A stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_range_controller urc_checker u_urc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
